/* design/khc_pkg.sv */
package khc_pkg;

  localparam int unsigned INDEX_W     = 14;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned KLEN_W      = 3;
  localparam int unsigned MAX_KMER    = 7;
  localparam int unsigned STORE_DEPTH = 16384;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned CLR_W       = ADDR_W + 1;

  localparam logic [KLEN_W-1:0] KLEN_RESET = KLEN_W'(5);
  localparam logic [KLEN_W-1:0] KLEN_MAX   = KLEN_W'(MAX_KMER);

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_C     = 8'h43;
  localparam logic [CHAR_W-1:0] CHAR_G     = 8'h47;
  localparam logic [CHAR_W-1:0] CHAR_T     = 8'h54;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_VT    = 8'h0B;
  localparam logic [CHAR_W-1:0] CHAR_FF    = 8'h0C;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;

  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_G = 2'd2;
  localparam logic [1:0] BASE_T = 2'd3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

endpackage

/* design/khc_ram.sv */
module khc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/kmer_histogram_counter.sv */
// Pipeline: an accepted item moves through stage s1 into the output register.
// Throughput: one item per cycle unless the output stalls, even back-to-back
//   hits on one k-mer; the count RAM is read at acceptance and written as the
//   item leaves s1, with the last write forwarded around the registered read.
// Reset: window, fill and k (=5) clear at once; the count RAM is then zeroed
//   one entry per cycle over all 16384 entries, during which no item is accepted.
module kmer_histogram_counter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [khc_pkg::KLEN_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic [khc_pkg::CHAR_W-1:0]    char_code_i,
  input  logic [khc_pkg::INDEX_W-1:0]   read_index_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [khc_pkg::INDEX_W-1:0]   kmer_index_o,
  output logic                          counted_o,
  output logic [khc_pkg::COUNT_W-1:0]   count_value_o
);

  localparam int unsigned IW = khc_pkg::INDEX_W;
  localparam int unsigned CW = khc_pkg::COUNT_W;
  localparam int unsigned AW = khc_pkg::ADDR_W;
  localparam int unsigned KW = khc_pkg::KLEN_W;

  // configuration and window state
  logic [KW-1:0] klen_q;
  logic [IW-1:0] window_q, window_d;
  logic [KW-1:0] fill_q, fill_d;
  logic [KW-1:0] k_eff;
  logic [IW-1:0] wmask;
  logic [15:0]   wmask_wide;

  // clearing sweep
  logic [khc_pkg::CLR_W-1:0] clr_q;
  logic                      clearing;

  // pipeline
  logic          s1_valid_q, s1_count_q, s1_read_q;
  logic [IW-1:0] s1_idx_q, s1_idx_d;
  logic          s1_count_d;
  logic          out_valid_q, counted_q;
  logic [IW-1:0] kmer_index_q;
  logic [CW-1:0] count_q;
  logic          out_free, s1_free, accept;

  // forwarding of the last write
  logic          fwd_valid_q;
  logic [AW-1:0] fwd_addr_q;
  logic [CW-1:0] fwd_data_q;

  logic [CW-1:0] ram_rdata, cur_count, inc_count;
  logic          ram_we, pipe_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [CW-1:0] ram_wdata;

  logic          is_blank, is_base;
  logic [1:0]    base_code;

  assign clearing    = !clr_q[khc_pkg::CLR_W-1];
  assign out_free    = !out_valid_q || !out_stall_i;
  assign s1_free     = !s1_valid_q || out_free;
  assign in_stall_o  = clearing || !s1_free;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    k_eff = klen_q;
    if (klen_q == '0) begin
      k_eff = KW'(1);
    end else if (klen_q > khc_pkg::KLEN_MAX) begin
      k_eff = khc_pkg::KLEN_MAX;
    end
  end

  assign wmask_wide = (16'd1 << {k_eff, 1'b0}) - 16'd1;
  assign wmask      = wmask_wide[IW-1:0];

  assign is_blank = (char_code_i == khc_pkg::CHAR_SPACE) ||
                    ((char_code_i >= khc_pkg::CHAR_TAB) && (char_code_i <= khc_pkg::CHAR_CR));

  always_comb begin
    is_base   = 1'b1;
    base_code = khc_pkg::BASE_A;
    case (char_code_i)
      khc_pkg::CHAR_A: base_code = khc_pkg::BASE_A;
      khc_pkg::CHAR_C: base_code = khc_pkg::BASE_C;
      khc_pkg::CHAR_G: base_code = khc_pkg::BASE_G;
      khc_pkg::CHAR_T: base_code = khc_pkg::BASE_T;
      default:         is_base   = 1'b0;
    endcase
  end

  // window update and next-stage decode for one item (character or read)
  always_comb begin
    window_d   = window_q;
    fill_d     = fill_q;
    s1_count_d = 1'b0;
    s1_idx_d   = '0;
    if (kind_i == khc_pkg::KIND_READ) begin
      s1_idx_d = read_index_i;
    end else if (!is_blank) begin
      if (is_base) begin
        window_d = {window_q[IW-3:0], base_code} & wmask;
        if (fill_q < k_eff) begin
          fill_d = fill_q + KW'(1);
        end
        if (fill_d >= k_eff) begin
          s1_count_d = 1'b1;
          s1_idx_d   = window_d;
        end
      end else begin
        window_d = '0;
        fill_d   = '0;
      end
    end
  end

  assign cur_count = (fwd_valid_q && (fwd_addr_q == s1_idx_q[AW-1:0])) ? fwd_data_q
                                                                       : ram_rdata;
  assign inc_count = (cur_count == khc_pkg::COUNT_MAX) ? cur_count : cur_count + CW'(1);

  assign pipe_we   = s1_valid_q && s1_count_q && out_free;
  assign ram_we    = clearing || pipe_we;
  assign ram_waddr = clearing ? clr_q[AW-1:0] : s1_idx_q[AW-1:0];
  assign ram_wdata = clearing ? '0 : inc_count;
  assign ram_raddr = s1_idx_d[AW-1:0];

  khc_ram #(
    .WIDTH(CW),
    .DEPTH(khc_pkg::STORE_DEPTH)
  ) u_count_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (accept),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      klen_q      <= khc_pkg::KLEN_RESET;
      window_q    <= '0;
      fill_q      <= '0;
      clr_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      if (clearing) begin
        clr_q <= clr_q + khc_pkg::CLR_W'(1);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        // new length: empty the window, keep the counts
        klen_q   <= cfg_data_i;
        window_q <= '0;
        fill_q   <= '0;
      end else if (accept) begin
        window_q <= window_d;
        fill_q   <= fill_d;
      end
      if (s1_free) begin
        s1_valid_q <= accept;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
      if (pipe_we) begin
        fwd_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_count_q <= s1_count_d;
      s1_read_q  <= (kind_i == khc_pkg::KIND_READ);
      s1_idx_q   <= s1_idx_d;
    end
    if (pipe_we) begin
      fwd_addr_q <= s1_idx_q[AW-1:0];
      fwd_data_q <= inc_count;
    end
    if (out_free && s1_valid_q) begin
      kmer_index_q <= s1_idx_q;
      counted_q    <= s1_count_q;
      if (s1_count_q) begin
        count_q <= inc_count;
      end else if (s1_read_q) begin
        count_q <= cur_count;
      end else begin
        count_q <= '0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kmer_index_o  = kmer_index_q;
  assign counted_o     = counted_q;
  assign count_value_o = count_q;

`ifndef SYNTH
  a_no_accept_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !accept)
    else $error("item accepted during count store clearing");

  a_pipe_idle_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !s1_valid_q && !out_valid_q)
    else $error("pipeline busy during count store clearing");

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= k_eff)
    else $error("window fill exceeds k-mer length");

  a_counted_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && counted_q |-> count_q != '0)
    else $error("counted result carries a zero count");

  a_blocked_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_free |=> s1_valid_q && $stable(s1_idx_q))
    else $error("blocked pipeline stage lost its item");
`endif

endmodule

/* dv/kmer_histogram_checker.sv */
`timescale 1ns / 1ps
module kmer_histogram_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [khc_pkg::KLEN_W-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic                        kind_i,
  input  logic [khc_pkg::CHAR_W-1:0]  char_code_i,
  input  logic [khc_pkg::INDEX_W-1:0] read_index_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [khc_pkg::INDEX_W-1:0] kmer_index_i,
  input  logic                        counted_i,
  input  logic [khc_pkg::COUNT_W-1:0] count_value_i,
  output int unsigned                 err_count_o,
  output int unsigned                 pending_o
);

  typedef struct packed {
    logic [khc_pkg::INDEX_W-1:0] kmer_index;
    logic                        counted;
    logic [khc_pkg::COUNT_W-1:0] count_value;
  } tally_t;

  logic [khc_pkg::COUNT_W-1:0] count_mem [khc_pkg::STORE_DEPTH];
  logic [khc_pkg::INDEX_W-1:0] window_q;
  int unsigned                 fill_q;
  logic [khc_pkg::KLEN_W-1:0]  klen_q;
  tally_t                      tally_q [$];
  int unsigned                 errs;

  function automatic tally_t tally_item(input logic kind,
                                        input logic [khc_pkg::CHAR_W-1:0] ch,
                                        input logic [khc_pkg::INDEX_W-1:0] rd);
    tally_t                      res;
    int unsigned                 k;
    int unsigned                 mask;
    logic [1:0]                  code;
    logic [khc_pkg::COUNT_W-1:0] cnt;
    res = '0;
    if (kind == khc_pkg::KIND_READ) begin
      res.kmer_index  = rd;
      res.count_value = count_mem[rd % khc_pkg::STORE_DEPTH];
      return res;
    end
    case (ch)
      khc_pkg::CHAR_SPACE, khc_pkg::CHAR_TAB, khc_pkg::CHAR_LF, khc_pkg::CHAR_VT,
      khc_pkg::CHAR_FF, khc_pkg::CHAR_CR: return res;
      khc_pkg::CHAR_A: code = khc_pkg::BASE_A;
      khc_pkg::CHAR_C: code = khc_pkg::BASE_C;
      khc_pkg::CHAR_G: code = khc_pkg::BASE_G;
      khc_pkg::CHAR_T: code = khc_pkg::BASE_T;
      default: begin
        // anything else breaks the window
        window_q = '0;
        fill_q   = 0;
        return res;
      end
    endcase
    k = (klen_q == '0) ? 1 :
        ((klen_q > khc_pkg::KLEN_MAX) ? khc_pkg::MAX_KMER : klen_q);
    mask = (1 << (2 * k)) - 1;
    window_q = khc_pkg::INDEX_W'(({window_q, 2'b00} | code) & mask);
    if (fill_q < k) fill_q++;
    if (fill_q < k) return res;
    cnt = count_mem[window_q % khc_pkg::STORE_DEPTH];
    if (cnt != khc_pkg::COUNT_MAX) cnt++;
    count_mem[window_q % khc_pkg::STORE_DEPTH] = cnt;
    res.kmer_index  = window_q;
    res.counted     = 1'b1;
    res.count_value = cnt;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tally_t want;
    if (!rst_ni) begin
      for (int i = 0; i < khc_pkg::STORE_DEPTH; i++) count_mem[i] = '0;
      window_q = '0;
      fill_q   = 0;
      klen_q   = khc_pkg::KLEN_RESET;
      tally_q.delete();
      errs = 0;
      err_count_o <= 0;
      pending_o   <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        klen_q   = cfg_data_i;
        window_q = '0;
        fill_q   = 0;
      end
      if (out_valid_i && !out_stall_i) begin
        if (tally_q.size() == 0) begin
          $display("%0t: unexpected result: index %h counted %b count %0d", $time,
                   kmer_index_i, counted_i, count_value_i);
          errs++;
        end else begin
          want = tally_q.pop_front();
          if (kmer_index_i !== want.kmer_index) begin
            $display("%0t: kmer_index expected %h, got %h", $time, want.kmer_index,
                     kmer_index_i);
            errs++;
          end
          if (counted_i !== want.counted) begin
            $display("%0t: counted expected %b, got %b", $time, want.counted, counted_i);
            errs++;
          end
          if (count_value_i !== want.count_value) begin
            $display("%0t: count_value expected %0d, got %0d", $time, want.count_value,
                     count_value_i);
            errs++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) tally_q.push_back(tally_item(kind_i, char_code_i,
                                                                   read_index_i));
      err_count_o <= errs;
      pending_o   <= tally_q.size();
    end
  end

endmodule

/* dv/kmer_histogram_counter_tb.sv */
`timescale 1ns / 1ps
module kmer_histogram_counter_tb;

  localparam int unsigned WATCHDOG_LIMIT = 80000;
  localparam int unsigned PHASE_ITEMS    = 240;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned PHASES         = 8;

  localparam logic [khc_pkg::CHAR_W-1:0] CHAR_N        = 8'h4E;
  localparam logic [khc_pkg::CHAR_W-1:0] CHAR_LOWER_A  = 8'h61;
  localparam logic [khc_pkg::CHAR_W-1:0] CHAR_NUL      = 8'h00;
  localparam logic [khc_pkg::CHAR_W-1:0] CHAR_ALL_ONES = 8'hFF;
  localparam logic [khc_pkg::CHAR_W-1:0] CASE_BIT      = 8'h20;

  logic                         clk_i        = 1'b0;
  logic                         rst_ni       = 1'b0;
  logic                         cfg_valid_i  = 1'b0;
  logic [khc_pkg::KLEN_W-1:0]   cfg_data_i   = '0;
  logic                         in_valid_i   = 1'b0;
  logic                         kind_i       = khc_pkg::KIND_CHAR;
  logic [khc_pkg::CHAR_W-1:0]   char_code_i  = '0;
  logic [khc_pkg::INDEX_W-1:0]  read_index_i = '0;
  logic                         out_stall_i  = 1'b0;
  logic                         cfg_ready_o;
  logic                         in_stall_o;
  logic                         out_valid_o;
  logic [khc_pkg::INDEX_W-1:0]  kmer_index_o;
  logic                         counted_o;
  logic [khc_pkg::COUNT_W-1:0]  count_value_o;

  int unsigned err_count;
  int unsigned pending;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_req      = 0;
  int unsigned hold_seen     = 0;
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned motif_pos     = 0;

  logic [khc_pkg::CHAR_W-1:0] base_chars  [4] = '{khc_pkg::CHAR_A, khc_pkg::CHAR_C,
                                                  khc_pkg::CHAR_G, khc_pkg::CHAR_T};
  logic [khc_pkg::CHAR_W-1:0] blank_chars [6] = '{khc_pkg::CHAR_SPACE, khc_pkg::CHAR_TAB,
                                                  khc_pkg::CHAR_LF, khc_pkg::CHAR_VT,
                                                  khc_pkg::CHAR_FF, khc_pkg::CHAR_CR};
  logic [khc_pkg::CHAR_W-1:0] motif       [8];

  kmer_histogram_counter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .char_code_i   (char_code_i),
    .read_index_i  (read_index_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kmer_index_o  (kmer_index_o),
    .counted_o     (counted_o),
    .count_value_o (count_value_o)
  );

  kmer_histogram_checker u_tally_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .kind_i        (kind_i),
    .char_code_i   (char_code_i),
    .read_index_i  (read_index_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kmer_index_i  (kmer_index_o),
    .counted_i     (counted_o),
    .count_value_i (count_value_o),
    .err_count_o   (err_count),
    .pending_o     (pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Hold off the output for a long stretch on request, else stall at random.
  always @(posedge clk_i) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic send_item(input logic kind, input logic [khc_pkg::CHAR_W-1:0] ch,
                           input logic [khc_pkg::INDEX_W-1:0] idx);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= kind;
    char_code_i  <= ch;
    read_index_i <= idx;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic write_klen(input logic [khc_pkg::KLEN_W-1:0] klen);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= klen;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Let the checker count the last transaction, drain every outstanding
  // result, then cover the pipeline latency.
  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_random(input int unsigned keff);
    int unsigned                 pick;
    logic [khc_pkg::CHAR_W-1:0]  ch;
    logic [khc_pkg::INDEX_W-1:0] idx;
    pick = $urandom_range(0, 99);
    ch   = khc_pkg::CHAR_W'($urandom_range(0, 255));
    idx  = khc_pkg::INDEX_W'($urandom_range(0, (1 << khc_pkg::INDEX_W) - 1));
    if (pick < 70) begin
      // mix a repeating motif with random bases so some k-mers recur
      if ($urandom_range(0, 1)) begin
        ch = motif[motif_pos % 8];
        motif_pos++;
      end else begin
        ch = base_chars[$urandom_range(0, 3)];
      end
      send_item(khc_pkg::KIND_CHAR, ch, idx);
    end else if (pick < 78) begin
      send_item(khc_pkg::KIND_CHAR, blank_chars[$urandom_range(0, 5)], idx);
    end else if (pick < 83) begin
      case ($urandom_range(0, 2))
        0: ch = CHAR_N;
        1: ch = base_chars[$urandom_range(0, 3)] | CASE_BIT;
        default: ;
      endcase
      send_item(khc_pkg::KIND_CHAR, ch, idx);
    end else begin
      if ($urandom_range(0, 9) < 7) begin
        idx = khc_pkg::INDEX_W'($urandom_range(0, (1 << (2 * keff)) - 1));
      end
      send_item(khc_pkg::KIND_READ, ch, idx);
    end
  endtask

  initial begin
    logic [khc_pkg::KLEN_W-1:0] klen_plan [PHASES];
    int unsigned                keff;
    klen_plan = '{3'd0, khc_pkg::KLEN_MAX, 3'd1, 3'd3, 3'd6, 3'd2, 3'd4,
                  khc_pkg::KLEN_MAX};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset length of five: count, skip blanks, break, read back
    send_item(khc_pkg::KIND_CHAR, khc_pkg::CHAR_A, '0);
    send_item(khc_pkg::KIND_CHAR, khc_pkg::CHAR_C, '1);
    send_item(khc_pkg::KIND_CHAR, khc_pkg::CHAR_G, '0);
    send_item(khc_pkg::KIND_CHAR, khc_pkg::CHAR_T, '1);
    send_item(khc_pkg::KIND_CHAR, khc_pkg::CHAR_A, '0);
    send_item(khc_pkg::KIND_CHAR, khc_pkg::CHAR_C, '0);
    foreach (blank_chars[i]) send_item(khc_pkg::KIND_CHAR, blank_chars[i], '1);
    send_item(khc_pkg::KIND_CHAR, khc_pkg::CHAR_G, '0);
    send_item(khc_pkg::KIND_CHAR, CHAR_LOWER_A, '0);
    send_item(khc_pkg::KIND_CHAR, CHAR_N, '0);
    send_item(khc_pkg::KIND_CHAR, CHAR_NUL, '0);
    send_item(khc_pkg::KIND_CHAR, CHAR_ALL_ONES, '1);
    repeat (4) send_item(khc_pkg::KIND_CHAR, khc_pkg::CHAR_T, '0);
    send_item(khc_pkg::KIND_READ, CHAR_ALL_ONES,
              khc_pkg::INDEX_W'({khc_pkg::BASE_A, khc_pkg::BASE_C, khc_pkg::BASE_G,
                                 khc_pkg::BASE_T, khc_pkg::BASE_A}));
    send_item(khc_pkg::KIND_READ, CHAR_NUL, '1);
    send_item(khc_pkg::KIND_READ, khc_pkg::CHAR_A, '0);
    send_item(khc_pkg::KIND_CHAR, khc_pkg::CHAR_T, '0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      write_klen(klen_plan[p]);
      keff = (klen_plan[p] == '0) ? 1 : klen_plan[p];
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 79; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 79; end
        default: begin send_idle_pct = 22; stall_pct = 22; end
      endcase
      foreach (motif[i]) motif[i] = base_chars[$urandom_range(0, 3)];
      // back up the block while the sender keeps offering
      if (p == 0) hold_req <= hold_req + 1;
      repeat (PHASE_ITEMS) send_random(keff);
      drain();
    end

    if (err_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
